/* hdl/imhdk_pkg.sv */
package imhdk_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int ID_SPACE_DEF = 1024;
  localparam int KEY_BITS_DEF = 48;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_PRESENT = 3'd4,
    ST_RAISED  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_LOOK,
    S_CHK,
    S_EXT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_e;

endpackage

/* hdl/indexed_min_heap_decrease_key_top.sv */
// channel   dir  fields (tdata, low bit first)
// s_axis    in   command, item_key, item_id, zero pad to bytes
// m_axis    out  status, out_key, out_id, entry_count, zero pad to bytes
//
// One command at a time: dispatch and lookup, then per heap level walked one
// level cell read and one compare and move, and a closing read or compare
// that places the entry.
// The worst case is a decrease that walks to the root, set by the sift loop;
// the next command is accepted only after the result has been taken.
// After reset every position map entry is cleared in turn; no command
// is taken meanwhile. s_axis_tready_o stays low while a result is unclaimed.
module indexed_min_heap_decrease_key_top #(
  parameter int CAPACITY = imhdk_pkg::CAPACITY_DEF,
  parameter int ID_SPACE = imhdk_pkg::ID_SPACE_DEF,
  parameter int KEY_BITS = imhdk_pkg::KEY_BITS_DEF,
  localparam int LV      = $clog2(CAPACITY + 1),
  localparam int CNT_W   = LV,
  localparam int ID_W    = $clog2(ID_SPACE),
  localparam int IN_W    = 2 + KEY_BITS + ID_W,
  localparam int IN_PW   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W   = 3 + KEY_BITS + ID_W + CNT_W,
  localparam int OUT_PW  = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_PW-1:0]  s_axis_tdata_i,  // command, item_key, item_id
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_PW-1:0] m_axis_tdata_o   // status, out_key, out_id, entry_count
);

  import imhdk_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int OW     = LV - 1;
  localparam int LW     = $clog2(LV);
  localparam int ENT_W  = ID_W + KEY_BITS;
  localparam int PW     = SLOT_W + 1;
  localparam int CW     = SLOT_W + 2;

  state_e state_q, state_d;
  logic [ID_W-1:0]  clr_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             m_valid_q;

  cmd_e              cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [ID_W-1:0]   id_q;
  logic [ENT_W-1:0]  ent_q;
  logic [SLOT_W-1:0] cur_s_q;
  logic [LW-1:0]     cur_lev_q;
  logic [OW-1:0]     cur_off_q;
  logic [KEY_BITS-1:0] res_key_q;
  logic [ID_W-1:0]   res_id_q;
  logic [LW-1:0]     rd_lev_a_q, rd_lev_b_q;

  status_e             o_status_q;
  logic [KEY_BITS-1:0] o_key_q;
  logic [ID_W-1:0]     o_id_q;
  logic [CNT_W-1:0]    o_cnt_q;

  logic s_acc, m_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = m_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && !m_valid_q;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_PW'({o_cnt_q, o_id_q, o_key_q, o_status_q});

  // level cells
  logic [LW-1:0]    rd_lev_a, rd_lev_b, wr_lev;
  logic [OW-1:0]    rd_off_a, rd_off_b, wr_off;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] cell_rda [LV];
  logic [ENT_W-1:0] cell_rdb [LV];

  for (genvar l = 0; l < LV; l++) begin : g_lev
    imhdk_level_cell #(
      .LEVEL(l),
      .LW   (LW),
      .OW   (OW),
      .ENT_W(ENT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rd_off_a_i (rd_off_a),
      .rd_off_b_i (rd_off_b),
      .wr_en_i    (wr_en),
      .wr_lev_i   (wr_lev),
      .wr_off_i   (wr_off),
      .wr_data_i  (wr_data),
      .rd_data_a_o(cell_rda[l]),
      .rd_data_b_o(cell_rdb[l])
    );
  end

  logic [ENT_W-1:0]    rda, rdb;
  logic [KEY_BITS-1:0] rda_key, rdb_key, ent_key;
  logic [ID_W-1:0]     rda_id, rdb_id, ent_id;
  assign rda     = cell_rda[rd_lev_a_q];
  assign rdb     = cell_rdb[rd_lev_b_q];
  assign rda_key = rda[KEY_BITS-1:0];
  assign rdb_key = rdb[KEY_BITS-1:0];
  assign ent_key = ent_q[KEY_BITS-1:0];
  assign rda_id  = rda[ENT_W-1 -: ID_W];
  assign rdb_id  = rdb[ENT_W-1 -: ID_W];
  assign ent_id  = ent_q[ENT_W-1 -: ID_W];

  // position map
  logic [ID_W-1:0] pm_wa;
  logic [PW-1:0]   pm_rd, pm_wd;
  logic            pm_we;
  logic            pm_present;
  logic [SLOT_W-1:0] pm_slot;

  imhdk_pos_map #(
    .ID_SPACE(ID_SPACE),
    .ID_W    (ID_W),
    .PW      (PW)
  ) u_pos_map (
    .clk_i    (clk_i),
    .rd_addr_i(id_q),
    .rd_data_o(pm_rd),
    .wr_en_i  (pm_we),
    .wr_addr_i(pm_wa),
    .wr_data_i(pm_wd)
  );
  assign pm_present = pm_rd[SLOT_W];
  assign pm_slot    = pm_rd[SLOT_W-1:0];

  // slot number to level and offset
  logic [CNT_W-1:0] cv_in, cv_p1;
  logic [LW-1:0]    cv_lev;
  logic [OW-1:0]    cv_off;

  always_comb begin
    if (state_q == S_DISP) begin
      cv_in = fill_q - 1'b1;
    end else if (cmd_q == CMD_INSERT) begin
      cv_in = fill_q;
    end else begin
      cv_in = CNT_W'(pm_slot);
    end
    cv_p1  = cv_in + 1'b1;
    cv_lev = '0;
    for (int i = 0; i < LV; i++) begin
      if (cv_p1[i]) cv_lev = LW'(i);
    end
    for (int i = 0; i < OW; i++) begin
      cv_off[i] = cv_p1[i] && (LW'(i) != cv_lev);
    end
  end

  // walk decisions
  logic [CW-1:0]     lch, rch;
  logic [SLOT_W-1:0] parent_s;
  logic id_bad, full, raised, up_move, l_valid, r_valid, l_big, r_big, dn_move, dn_sel;

  assign id_bad   = {1'b0, id_q} >= (ID_W + 1)'(ID_SPACE);
  assign full     = fill_q >= CNT_W'(CAPACITY);
  assign raised   = key_q > rda_key;
  assign up_move  = ent_key < rda_key;
  assign lch      = {1'b0, cur_s_q, 1'b0} + CW'(1);
  assign rch      = lch + CW'(1);
  assign parent_s = (cur_s_q - 1'b1) >> 1;
  assign l_valid  = lch < CW'(fill_q);
  assign r_valid  = rch < CW'(fill_q);
  assign l_big    = ent_key > rda_key;
  assign r_big    = r_valid && (ent_key > rdb_key);
  assign dn_move  = l_big || r_big;
  assign dn_sel   = r_valid && !(rda_key < rdb_key);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:    if (clr_q == ID_W'(ID_SPACE - 1)) state_d = S_IDLE;
      S_IDLE:   if (s_acc) state_d = S_DISP;
      S_DISP: begin
        case (cmd_q) inside
          CMD_INSERT, CMD_DECREASE: state_d = id_bad ? S_IDLE : S_LOOK;
          CMD_EXTRACT:              state_d = (fill_q == '0) ? S_IDLE : S_EXT;
          default:                  state_d = S_IDLE;
        endcase
      end
      S_LOOK: begin
        if (cmd_q == CMD_INSERT) begin
          state_d = (pm_present || full) ? S_IDLE : S_UP_RD;
        end else begin
          state_d = pm_present ? S_CHK : S_IDLE;
        end
      end
      S_CHK:    state_d = raised ? S_IDLE : S_UP_RD;
      S_EXT:    state_d = (fill_q == CNT_W'(1)) ? S_IDLE : S_DN_RD;
      S_UP_RD:  state_d = (cur_lev_q == '0) ? S_IDLE : S_UP_CMP;
      S_UP_CMP: state_d = up_move ? S_UP_RD : S_IDLE;
      S_DN_RD:  state_d = l_valid ? S_DN_CMP : S_IDLE;
      S_DN_CMP: state_d = dn_move ? S_DN_RD : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  logic    fin, place;
  status_e fin_status;

  always_comb begin
    fin        = 1'b0;
    fin_status = ST_OK;
    place      = 1'b0;
    rd_lev_a   = '0;
    rd_off_a   = '0;
    rd_lev_b   = '0;
    rd_off_b   = '0;
    wr_en      = 1'b0;
    wr_lev     = cur_lev_q;
    wr_off     = cur_off_q;
    wr_data    = ent_q;
    pm_we      = 1'b0;
    pm_wa      = ent_id;
    pm_wd      = {1'b1, cur_s_q};
    fill_d     = fill_q;
    unique case (state_q)
      S_CLR: begin
        pm_we = 1'b1;
        pm_wa = clr_q;
        pm_wd = '0;
      end
      S_DISP: begin
        case (cmd_q) inside
          CMD_INSERT, CMD_DECREASE: begin
            if (id_bad) begin
              fin        = 1'b1;
              fin_status = ST_ABSENT;
            end
          end
          CMD_EXTRACT: begin
            if (fill_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              rd_lev_b = cv_lev;
              rd_off_b = cv_off;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_LOOK: begin
        if (cmd_q == CMD_INSERT) begin
          if (pm_present) begin
            fin        = 1'b1;
            fin_status = ST_PRESENT;
          end else if (full) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end else if (!pm_present) begin
          fin        = 1'b1;
          fin_status = ST_ABSENT;
        end else begin
          rd_lev_a = cv_lev;
          rd_off_a = cv_off;
        end
      end
      S_CHK: begin
        if (raised) begin
          fin        = 1'b1;
          fin_status = ST_RAISED;
        end
      end
      S_EXT: begin
        fill_d = fill_q - 1'b1;
        pm_we  = 1'b1;
        pm_wa  = rda_id;
        pm_wd  = '0;
        if (fill_q == CNT_W'(1)) fin = 1'b1;
      end
      S_UP_RD: begin
        if (cur_lev_q == '0) begin
          place = 1'b1;
        end else begin
          rd_lev_a = cur_lev_q - 1'b1;
          rd_off_a = cur_off_q >> 1;
        end
      end
      S_UP_CMP: begin
        if (up_move) begin
          wr_en   = 1'b1;
          wr_data = rda;
          pm_we   = 1'b1;
          pm_wa   = rda_id;
        end else begin
          place = 1'b1;
        end
      end
      S_DN_RD: begin
        if (l_valid) begin
          rd_lev_a = cur_lev_q + 1'b1;
          rd_off_a = {cur_off_q[OW-2:0], 1'b0};
          rd_lev_b = cur_lev_q + 1'b1;
          rd_off_b = {cur_off_q[OW-2:0], 1'b1};
        end else begin
          place = 1'b1;
        end
      end
      S_DN_CMP: begin
        if (dn_move) begin
          wr_en   = 1'b1;
          wr_data = dn_sel ? rdb : rda;
          pm_we   = 1'b1;
          pm_wa   = dn_sel ? rdb_id : rda_id;
        end else begin
          place = 1'b1;
        end
      end
      default: ;
    endcase
    if (place) begin
      fin   = 1'b1;
      wr_en = 1'b1;
      pm_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (fin) begin
        m_valid_q <= 1'b1;
      end else if (m_acc) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lev_a_q <= rd_lev_a;
    rd_lev_b_q <= rd_lev_b;
    if (s_acc) begin
      cmd_q     <= cmd_e'(s_axis_tdata_i[1:0]);
      key_q     <= s_axis_tdata_i[2 +: KEY_BITS];
      id_q      <= s_axis_tdata_i[2 + KEY_BITS +: ID_W];
      res_key_q <= '0;
      res_id_q  <= '0;
    end
    case (state_q)
      S_LOOK: begin
        ent_q     <= {id_q, key_q};
        cur_lev_q <= cv_lev;
        cur_off_q <= cv_off;
        cur_s_q   <= (cmd_q == CMD_INSERT) ? fill_q[SLOT_W-1:0] : pm_slot;
      end
      S_EXT: begin
        res_key_q <= rda_key;
        res_id_q  <= rda_id;
        ent_q     <= rdb;
        cur_s_q   <= '0;
        cur_lev_q <= '0;
        cur_off_q <= '0;
      end
      S_UP_CMP: begin
        if (up_move) begin
          cur_s_q   <= parent_s;
          cur_lev_q <= cur_lev_q - 1'b1;
          cur_off_q <= cur_off_q >> 1;
        end
      end
      S_DN_CMP: begin
        if (dn_move) begin
          cur_s_q   <= dn_sel ? rch[SLOT_W-1:0] : lch[SLOT_W-1:0];
          cur_lev_q <= cur_lev_q + 1'b1;
          cur_off_q <= {cur_off_q[OW-2:0], dn_sel};
        end
      end
      default: ;
    endcase
    if (fin) begin
      o_status_q <= fin_status;
      o_key_q    <= (state_q == S_EXT) ? rda_key : res_key_q;
      o_id_q     <= (state_q == S_EXT) ? rda_id : res_id_q;
      o_cnt_q    <= fill_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |->
      ((fill_q == $past(fill_q) + 1'b1) || (fill_q + 1'b1 == $past(fill_q))))
    else $error("entry count moved by more than one");

  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q == S_DISP))
    else $error("accepted transaction not dispatched");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(fin))
    else $error("result raised without a finished command");

endmodule

/* hdl/imhdk_level_cell.sv */
module imhdk_level_cell #(
  parameter int LEVEL = 0,
  parameter int LW    = 4,
  parameter int OW    = 10,
  parameter int ENT_W = 58
) (
  input  logic             clk_i,
  input  logic [OW-1:0]    rd_off_a_i,
  input  logic [OW-1:0]    rd_off_b_i,
  input  logic             wr_en_i,
  input  logic [LW-1:0]    wr_lev_i,
  input  logic [OW-1:0]    wr_off_i,
  input  logic [ENT_W-1:0] wr_data_i,
  output logic [ENT_W-1:0] rd_data_a_o,
  output logic [ENT_W-1:0] rd_data_b_o
);

  localparam int IW    = (LEVEL == 0) ? 1 : LEVEL;
  localparam int DEPTH = 1 << IW;

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_lev_i == LW'(LEVEL))) begin
      mem[wr_off_i[IW-1:0]] <= wr_data_i;
    end
    rd_data_a_o <= mem[rd_off_a_i[IW-1:0]];
    rd_data_b_o <= mem[rd_off_b_i[IW-1:0]];
  end

endmodule

/* hdl/imhdk_pos_map.sv */
module imhdk_pos_map #(
  parameter int ID_SPACE = 1024,
  parameter int ID_W     = 10,
  parameter int PW       = 11
) (
  input  logic            clk_i,
  input  logic [ID_W-1:0] rd_addr_i,
  output logic [PW-1:0]   rd_data_o,
  input  logic            wr_en_i,
  input  logic [ID_W-1:0] wr_addr_i,
  input  logic [PW-1:0]   wr_data_i
);

  logic [PW-1:0] mem [ID_SPACE];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
